// ===== rtl/shamh_pkg.sv =====
// Package with the shared types, constants and round functions of the SHA-256 hasher.
package shamh_pkg;

  localparam int unsigned ROUNDS = 64;
  localparam int unsigned BLOCK_BITS = 512;
  localparam int unsigned CNT_W = 61;

  localparam logic [5:0] FILL_LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST = 3'd7;
  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INITIAL_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_COMPRESS,
    ST_UPDATE,
    ST_OUTPUT
  } state_e;

  typedef enum logic [1:0] {
    AFT_IDLE,
    AFT_MARK,
    AFT_ZERO,
    AFT_OUT
  } after_e;

  typedef enum logic [1:0] {
    SRC_INPUT,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } byte_src_e;

  typedef struct packed {
    logic      push;
    byte_src_e src;
    logic      count_byte;
    logic      load_work;
    logic      round_en;
    logic [5:0] round;
    logic      update_chain;
    logic      init_chain;
    logic [2:0] word_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } dp_status_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
    ror32 = (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== rtl/sha256_message_hasher_top.sv =====
// Top level of the SHA-256 message hasher with stream input and output channels.
// Throughput: one byte per cycle while a block fills; a full block holds the input during its rounds and update.
// After the finishing transaction the hasher pads and compresses the last block, and a second
// block when padding needs one; then it gives eight output transactions.
// Reset is asynchronous and active low; it loads the initial hash values and clears counts.
module sha256_message_hasher_top
  import shamh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] byte_present
  input  logic        s_axis_tlast_i,   // end_of_message
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_axis_tlast_o    // last_word
);

  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [31:0] digest_word;
  logic [2:0]  word_index;

  // The controller sequences byte intake, padding, the 64 rounds and the digest readout.
  // Padding bytes travel through the same byte shift path as message bytes, so the
  // block buffer and the message schedule share one 512-bit shift register.
  shamh_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid_i),
    .byte_present_i   (s_axis_tuser_i),
    .end_of_message_i (s_axis_tlast_i),
    .in_ready_o       (s_axis_tready_o),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .word_index_o     (word_index),
    .last_word_o      (m_axis_tlast_o),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  // The datapath holds the block, the byte count, the working words and the chaining words.
  shamh_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (s_axis_tdata_i),
    .status_o      (status),
    .digest_word_o (digest_word)
  );

  // Each output transaction carries one chaining word read straight from its register.
  assign m_axis_tdata_o = {5'b00000, word_index, digest_word};

endmodule

// ===== rtl/shamh_datapath.sv =====
// Datapath of the SHA-256 hasher: block shift register, schedule, rounds and chaining words.
module shamh_datapath
  import shamh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [7:0]  data_byte_i,
  output dp_status_t  status_o,
  output logic [31:0] digest_word_o
);

  // The block is a shift line: bytes enter at the bottom, and during the rounds
  // the top word is the current schedule word while the new one enters below.
  logic [BLOCK_BITS-1:0] blk_q, blk_d;
  logic [5:0]            fill_q, fill_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [31:0]           chain_q [8];
  logic [31:0]           chain_d [8];
  logic [31:0]           work_q [8];
  logic [31:0]           work_d [8];

  logic [63:0] len_sh;
  logic [7:0]  push_byte;
  logic [31:0] w_cur, w_new, t1, t2, ch, maj;

  always_comb begin
    len_sh = {cnt_q, 3'b000} << {fill_q[2:0], 3'b000};
    unique case (cmd_i.src)
      SRC_INPUT: push_byte = data_byte_i;
      SRC_MARK:  push_byte = PAD_MARK_BYTE;
      SRC_ZERO:  push_byte = 8'h00;
      SRC_LEN:   push_byte = len_sh[63:56];
      default:   push_byte = 8'h00;
    endcase
  end

  always_comb begin
    w_cur = blk_q[511:480];
    w_new = w_cur + small_sigma0(blk_q[479:448]) + blk_q[223:192]
          + small_sigma1(blk_q[63:32]);
    ch    = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
    maj   = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
    t1    = work_q[7] + big_sigma1(work_q[4]) + ch + ROUND_K[cmd_i.round] + w_cur;
    t2    = big_sigma0(work_q[0]) + maj;
  end

  always_comb begin
    blk_d  = blk_q;
    fill_d = fill_q;
    cnt_d  = cnt_q;
    if (cmd_i.push) begin
      blk_d  = {blk_q[BLOCK_BITS-9:0], push_byte};
      fill_d = fill_q + 6'd1;
    end else if (cmd_i.round_en) begin
      blk_d = {blk_q[BLOCK_BITS-33:0], w_new};
    end
    if (cmd_i.init_chain) begin
      cnt_d = '0;
    end else if (cmd_i.count_byte) begin
      cnt_d = cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      work_d[i]  = work_q[i];
      chain_d[i] = chain_q[i];
      if (cmd_i.load_work) begin
        work_d[i] = chain_q[i];
      end
      if (cmd_i.update_chain) begin
        chain_d[i] = chain_q[i] + work_q[i];
      end else if (cmd_i.init_chain) begin
        chain_d[i] = INITIAL_H[i];
      end
    end
    if (cmd_i.round_en) begin
      work_d[7] = work_q[6];
      work_d[6] = work_q[5];
      work_d[5] = work_q[4];
      work_d[4] = work_q[3] + t1;
      work_d[3] = work_q[2];
      work_d[2] = work_q[1];
      work_d[1] = work_q[0];
      work_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cnt_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= INITIAL_H[i];
      end
    end else begin
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q  <= blk_d;
    work_q <= work_d;
  end

  assign status_o.fill = fill_q;
  assign digest_word_o = chain_q[cmd_i.word_sel];

endmodule

// ===== rtl/shamh_ctrl.sv =====
// Controller of the SHA-256 hasher: byte intake, padding sequence, rounds and digest output.
module shamh_ctrl
  import shamh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       byte_present_i,
  input  logic       end_of_message_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] word_index_o,
  output logic       last_word_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e     state_q, state_d;
  after_e     after_q, after_d;
  logic [5:0] round_q, round_d;
  logic [2:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      after_q <= AFT_IDLE;
      round_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      round_q <= round_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    after_d = after_q;
    round_d = round_q;
    idx_d   = idx_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o = '{push: 1'b0, src: SRC_INPUT, count_byte: 1'b0, load_work: 1'b0,
              round_en: 1'b0, round: round_q, update_chain: 1'b0,
              init_chain: 1'b0, word_sel: idx_q};

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (byte_present_i) begin
            cmd_o.push       = 1'b1;
            cmd_o.count_byte = 1'b1;
            if (status_i.fill == FILL_LAST) begin
              cmd_o.load_work = 1'b1;
              round_d = '0;
              state_d = ST_COMPRESS;
              after_d = end_of_message_i ? AFT_MARK : AFT_IDLE;
            end else if (end_of_message_i) begin
              state_d = ST_PAD_MARK;
            end
          end else if (end_of_message_i) begin
            state_d = ST_PAD_MARK;
          end
        end
      end
      ST_PAD_MARK: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = SRC_MARK;
        if (status_i.fill == FILL_LAST) begin
          cmd_o.load_work = 1'b1;
          round_d = '0;
          state_d = ST_COMPRESS;
          after_d = AFT_ZERO;
        end else begin
          state_d = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (status_i.fill == FILL_LEN_START) begin
          state_d = ST_PAD_LEN;
        end else begin
          cmd_o.push = 1'b1;
          cmd_o.src  = SRC_ZERO;
          if (status_i.fill == FILL_LAST) begin
            cmd_o.load_work = 1'b1;
            round_d = '0;
            state_d = ST_COMPRESS;
            after_d = AFT_ZERO;
          end
        end
      end
      ST_PAD_LEN: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = SRC_LEN;
        if (status_i.fill == FILL_LAST) begin
          cmd_o.load_work = 1'b1;
          round_d = '0;
          state_d = ST_COMPRESS;
          after_d = AFT_OUT;
        end
      end
      ST_COMPRESS: begin
        cmd_o.round_en = 1'b1;
        round_d = round_q + 6'd1;
        if (round_q == ROUND_LAST) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update_chain = 1'b1;
        unique case (after_q)
          AFT_IDLE: state_d = ST_IDLE;
          AFT_MARK: state_d = ST_PAD_MARK;
          AFT_ZERO: state_d = ST_PAD_ZERO;
          AFT_OUT: begin
            state_d = ST_OUTPUT;
            idx_d   = '0;
          end
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_OUTPUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == WORD_LAST) begin
            cmd_o.init_chain = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == WORD_LAST);

endmodule
